[src/rps_pkg.sv]
// shared types and constants of the read pattern scanner
// used by rps_cell, rps_emit and read_pattern_scanner_core; no dependencies
package rps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_READ    = 1024;

    localparam int BYTE_W   = 8;
    localparam int PTR_W    = $clog2(MAX_PATTERN);
    localparam int LEN_W    = 5;
    localparam int CNT_W    = $clog2(MAX_READ) + 1;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 32;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 64;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 56;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    // per-cycle control handed to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // per-read summary loaded into the result sequencer
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0]   len;
    } rps_result_t;

endpackage

[src/read_pattern_scanner_core.sv]
// read pattern scanner top level: window cell chain, match latch and counter
// depends on rps_pkg, rps_cell and rps_emit
//
// Usage:
//   s_* takes one read character per word: base in tdata[7:0], quality in
//   tdata[15:8], tlast on the last character of the read.
//   cfg_* writes the pattern registers (0: bytes 0-7, 1: bytes 8-15,
//   2: length) and is always ready; the user must write it only while the
//   block idles, not enforced by the block. m_* gives the results of a read:
//   one word with found low if the pattern did not occur, otherwise
//   pattern-length words with the captured qualities, tlast on the last one.
//   Throughput: one character per cycle; the 16-cell window chain shifts and
//   compares in the cycle a character is accepted.
//   Latency: the first result word is valid the cycle after the tlast word
//   is accepted. A read's results take 1 to 16 beats at the output; a tlast
//   word is held off only while a previous read's results are still draining.
//   Reset clears the window, counters and pattern (length 1). When m_tready
//   is low, results hold and characters other than a read's last keep
//   flowing in.
module read_pattern_scanner_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: base_char[7:0], quality_char[15:8]
    input  logic [rps_pkg::IN_W-1:0]    s_tdata,
    // s_tlast: read_end
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: match_start[9:0], reads_matched[41:10], quality_byte[49:42],
    //          quality_offset[53:50], zero[55:54]
    output logic [rps_pkg::OUT_W-1:0]   m_tdata,
    // m_tuser: found
    output logic                        m_tuser,
    // m_tlast: last_result
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rps_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rps_pkg::CFG_W-1:0]   cfg_data
);
    import rps_pkg::*;

    logic [CFG_W-1:0]   pat_low_reg, pat_high_reg;
    logic [LEN_W-1:0]   pat_len_reg;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic               latched_reg, latched_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    byte_t              cap_reg [MAX_PATTERN];
    byte_t              cap_new [MAX_PATTERN];
    byte_t              cap_out [MAX_PATTERN];

    byte_t              pat_bytes [MAX_PATTERN];
    byte_t              base_q [MAX_PATTERN];
    byte_t              qual_q [MAX_PATTERN];
    byte_t              base_in [MAX_PATTERN];
    byte_t              qual_in [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;

    logic [LEN_W-1:0]   len_act;
    logic [CNT_W-1:0]   seen_inc;
    logic               in_fire, read_end, shift, match_now, emit_free;
    logic [START_W-1:0] start_new;
    cell_ctl_t          ctl;
    rps_result_t        res;

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // active pattern length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (pat_len_reg == '0)
            len_act = LEN_W'(1);
        else if (pat_len_reg > LEN_W'(MAX_PATTERN))
            len_act = LEN_W'(MAX_PATTERN);
        else
            len_act = pat_len_reg;
    end

    // pattern split into bytes
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN / 2; k++)
        begin
            pat_bytes[k]                   = pat_low_reg[k*BYTE_W +: BYTE_W];
            pat_bytes[k + MAX_PATTERN / 2] = pat_high_reg[k*BYTE_W +: BYTE_W];
        end
    end

    // input handshake: a read's last word waits for the sequencer
    assign read_end = s_tlast;
    assign s_tready = !read_end || emit_free;
    assign in_fire  = s_tvalid && s_tready;
    assign shift    = in_fire && (seen_reg < CNT_W'(MAX_READ));
    assign ctl.shift = shift;
    assign ctl.clear = in_fire && read_end;

    // window chain, newest character enters the top cell
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            base_in[i] = base_q[i + 1];
            qual_in[i] = qual_q[i + 1];
        end
        base_in[MAX_PATTERN-1] = s_tdata[BYTE_W-1:0];
        qual_in[MAX_PATTERN-1] = s_tdata[2*BYTE_W-1:BYTE_W];
    end

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic [PTR_W-1:0] pidx;
        logic [LEN_W:0]   reach;

        assign pidx  = PTR_W'(i) + len_act[PTR_W-1:0];
        assign reach = (LEN_W+1)'(i) + {1'b0, len_act};

        rps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .base_in  (base_in[i]),
            .qual_in  (qual_in[i]),
            .pat_byte (pat_bytes[pidx]),
            .use_byte (reach >= (LEN_W+1)'(MAX_PATTERN)),
            .base_q   (base_q[i]),
            .qual_q   (qual_q[i]),
            .hit      (hit[i])
        );
    end

    // match detection on the window after this character
    assign seen_inc  = seen_reg + CNT_W'(1);
    assign match_now = shift && !latched_reg && (seen_inc >= CNT_W'(len_act)) && (&hit);
    assign start_new = START_W'(seen_inc - CNT_W'(len_act));

    // qualities under the match, zero beyond the pattern length
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (LEN_W'(k) < len_act)
                cap_new[k] = qual_in[PTR_W'(k) - len_act[PTR_W-1:0]];
            else
                cap_new[k] = '0;
            cap_out[k] = match_now ? cap_new[k] : cap_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_now)
            cap_reg <= cap_new;
    end

    // read summary for the sequencer
    always_comb
    begin
        res.found = latched_reg || match_now;
        res.start = match_now ? start_new : start_reg;
        res.len   = len_act;
        if (res.found && (count_reg != '1))
            res.count = count_reg + COUNT_W'(1);
        else
            res.count = count_reg;
    end

    // per-read state
    always_comb
    begin
        seen_next    = seen_reg;
        latched_next = latched_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        if (in_fire && read_end)
        begin
            seen_next    = '0;
            latched_next = 1'b0;
            start_next   = '0;
            count_next   = res.count;
        end
        else
        begin
            if (shift)
                seen_next = seen_inc;
            if (match_now)
            begin
                latched_next = 1'b1;
                start_next   = start_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            latched_reg <= 1'b0;
            start_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            seen_reg    <= seen_next;
            latched_reg <= latched_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
        end
    end

    // result sequencer
    rps_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire && read_end),
        .res      (res),
        .cap      (cap_out),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[src/rps_cell.sv]
// one window cell: holds one base and its quality, compares the incoming base
// with its aligned pattern byte; depends on rps_pkg
module rps_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  rps_pkg::cell_ctl_t ctl,
    input  rps_pkg::byte_t    base_in,
    input  rps_pkg::byte_t    qual_in,
    input  rps_pkg::byte_t    pat_byte,
    input  logic              use_byte,
    output rps_pkg::byte_t    base_q,
    output rps_pkg::byte_t    qual_q,
    output logic              hit
);
    import rps_pkg::*;

    byte_t base_reg, base_next;
    byte_t qual_reg, qual_next;

    // shift from the neighbour, clear at end of read
    always_comb
    begin
        base_next = base_reg;
        qual_next = qual_reg;
        if (ctl.clear)
        begin
            base_next = '0;
            qual_next = '0;
        end
        else if (ctl.shift)
        begin
            base_next = base_in;
            qual_next = qual_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            qual_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
            qual_reg <= qual_next;
        end
    end

    // compare the byte about to enter this cell
    assign hit    = !use_byte || (base_in == pat_byte);
    assign base_q = base_reg;
    assign qual_q = qual_reg;

endmodule

[src/rps_emit.sv]
// result sequencer: holds one read's summary and captured qualities and
// walks them out one word per beat; depends on rps_pkg
module rps_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  rps_pkg::rps_result_t   res,
    input  rps_pkg::byte_t         cap [rps_pkg::MAX_PATTERN],
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: match_start[9:0], reads_matched[41:10], quality_byte[49:42],
    //          quality_offset[53:50], zero[55:54]
    output logic [rps_pkg::OUT_W-1:0] m_tdata,
    // m_tuser: found
    output logic                   m_tuser,
    // m_tlast: last_result
    output logic                   m_tlast
);
    import rps_pkg::*;

    logic        busy_reg, busy_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    rps_result_t res_reg;
    byte_t       cap_reg [MAX_PATTERN];

    logic  last;
    logic  beat;
    byte_t qbyte;

    assign last  = !res_reg.found || ({1'b0, idx_reg} == res_reg.len - LEN_W'(1));
    assign beat  = busy_reg && m_tready;
    assign free  = !busy_reg || (m_tready && last);
    assign qbyte = res_reg.found ? cap_reg[idx_reg] : '0;

    // beat counter and busy flag
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (beat)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // summary and qualities of the read being reported
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
            cap_reg <= cap;
        end
    end

    // output word
    assign m_tvalid = busy_reg;
    assign m_tuser  = res_reg.found;
    assign m_tlast  = last;
    assign m_tdata  = {2'b00, idx_reg, qbyte, res_reg.count, res_reg.start};

endmodule
